// File: hw/rtl/mvsm_pkg.sv
// package for the multi-voice sample mixer: payload types, mode and status codes
// no dependencies

package mvsm_pkg;

  localparam int VOICES_DEF       = 8;
  localparam int SOUNDS_DEF       = 8;
  localparam int SAMPLE_WORDS_DEF = 131072;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_SET    = 3'd2,
    MODE_PLAY   = 3'd3,
    MODE_LOOP   = 3'd4,
    MODE_STOP   = 3'd5,
    MODE_NONE6  = 3'd6,
    MODE_NONE7  = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_VOICE = 2'd1,
    ST_BAD_SND  = 2'd2,
    ST_BAD_VOICE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [2:0]         sound_id;
    logic [16:0]        sample_address;
    logic signed [15:0] sample_value;
    logic [16:0]        sound_start;
    logic [17:0]        sound_length;
    logic [8:0]         volume;
    logic [2:0]         voice_index;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic [2:0]         voice_slot;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_READ,
    BK_MUL,
    BK_ACC,
    BK_DONE
  } bk_state_t;

endpackage

// File: hw/rtl/mvsm_queue.sv
// two-entry word queue between front and back
// depends on mvsm_pkg

module mvsm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  mvsm_pkg::in_item_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output mvsm_pkg::in_item_t rd_data,
  output logic               empty
);
  import mvsm_pkg::*;

  in_item_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wp_r <= ~wp_r;
      end
      if (rd_en) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

// File: hw/rtl/mvsm_back.sv
// back end: sound table, voices, sample memory, shared multiplier and result register
// depends on mvsm_pkg

module mvsm_back #(
  parameter int VOICES       = mvsm_pkg::VOICES_DEF,
  parameter int SOUNDS       = mvsm_pkg::SOUNDS_DEF,
  parameter int SAMPLE_WORDS = mvsm_pkg::SAMPLE_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  mvsm_pkg::in_item_t  q_data,
  output logic                q_rd,
  output logic                out_valid,
  input  logic                out_stall,
  output mvsm_pkg::out_item_t out_data
);
  import mvsm_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] WORDS = PW'(SAMPLE_WORDS);

  logic signed [15:0] smem [SAMPLE_WORDS];
  logic signed [15:0] rdata_r;

  logic [16:0] snd_first_r [SOUNDS];
  logic [17:0] snd_len_r [SOUNDS];

  logic [VOICES-1:0] v_act_r;
  logic [VOICES-1:0] v_rep_r;
  logic [SW-1:0]     v_snd_r [VOICES];
  logic [PW-1:0]     v_pos_r [VOICES];
  logic [8:0]        v_gain_r [VOICES];

  bk_state_t state_r, state_nxt;
  logic [VW:0] vi_r;
  logic signed [17:0] acc_r;
  logic [24:0] prod_r;
  logic        neg_r;
  out_item_t   res_r;

  logic [VW-1:0]  vi;
  logic [SW-1:0]  vs;
  logic [PW-1:0]  len;
  logic [17:0]    cnt_raw;
  logic [PW-1:0]  pos_eff;
  logic           play_ok, skip;
  logic [AW-1:0]  rd_addr;
  logic [PW:0]    addr_sum;

  assign vi = vi_r[VW-1:0];
  assign vs = v_snd_r[vi];
  assign cnt_raw = snd_len_r[vs];
  always_comb begin
    if ({14'd0, cnt_raw} > 32'(WORDS)) begin
      len = WORDS;
    end else begin
      len = PW'(cnt_raw);
    end
    skip    = 1'b0;
    pos_eff = v_pos_r[vi];
    if (!v_act_r[vi]) begin
      skip = 1'b1;
    end else if (v_pos_r[vi] >= len) begin
      if (v_rep_r[vi] && len != '0) begin
        pos_eff = '0;
      end else begin
        skip = 1'b1;
      end
    end
    addr_sum = (PW+1)'(snd_first_r[vs]) + (PW+1)'(pos_eff);
    rd_addr  = AW'(addr_sum);
  end

  // lowest free voice for play
  logic [VW-1:0] free_idx;
  logic          free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!v_act_r[i]) begin
        free_idx = VW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic sid_ok;
  assign sid_ok  = ({29'd0, q_data.sound_id} < 32'(SOUNDS));
  assign play_ok = sid_ok && (snd_len_r[SW'(q_data.sound_id)] != 18'd0);

  logic fire;
  assign fire = (state_r == BK_IDLE) && !q_empty && !(out_valid && out_stall);
  assign q_rd = fire;
  assign out_data = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (fire && q_data.mode == MODE_TICK) state_nxt = BK_SCAN;
      BK_SCAN: begin
        if (vi_r == (VW+1)'(VOICES)) state_nxt = BK_DONE;
        else if (!skip) state_nxt = BK_READ;
      end
      BK_READ: state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_ACC;
      BK_ACC:  state_nxt = BK_SCAN;
      BK_DONE: if (!(out_valid && out_stall)) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  logic [15:0] mag;
  logic signed [18:0] sum;
  assign mag = rdata_r[15] ? 16'(-rdata_r) : 16'(rdata_r);
  assign sum = 19'(acc_r) + (neg_r ? -19'(prod_r[24:8]) : 19'(prod_r[24:8]));

  always_ff @(posedge clk) begin
    if (fire && q_data.mode == MODE_WRITE) begin
      smem[AW'(q_data.sample_address)] <= q_data.sample_value;
    end
    if (state_r == BK_SCAN) begin
      rdata_r <= smem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_valid <= 1'b0;
      v_act_r   <= '0;
      v_rep_r   <= '0;
      vi_r      <= '0;
      for (int i = 0; i < SOUNDS; i++) begin
        snd_first_r[i] <= '0;
        snd_len_r[i]   <= '0;
      end
      for (int i = 0; i < VOICES; i++) begin
        v_snd_r[i]  <= '0;
        v_pos_r[i]  <= '0;
        v_gain_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (fire) begin
        res_r <= '0;
        vi_r  <= '0;
        acc_r <= '0;
        case (q_data.mode)
          MODE_TICK: ;
          MODE_WRITE: out_valid <= 1'b1;
          MODE_SET: begin
            out_valid <= 1'b1;
            if (sid_ok) begin
              snd_first_r[SW'(q_data.sound_id)] <= q_data.sound_start;
              snd_len_r[SW'(q_data.sound_id)]   <= q_data.sound_length;
            end else begin
              res_r.status <= ST_BAD_SND;
            end
          end
          MODE_PLAY, MODE_LOOP: begin
            out_valid <= 1'b1;
            if (!play_ok) res_r.status <= ST_BAD_SND;
            else if (!free_any) res_r.status <= ST_NO_VOICE;
            else begin
              v_act_r[free_idx]  <= 1'b1;
              v_rep_r[free_idx]  <= (q_data.mode == MODE_LOOP);
              v_snd_r[free_idx]  <= SW'(q_data.sound_id);
              v_pos_r[free_idx]  <= '0;
              v_gain_r[free_idx] <= q_data.volume;
              res_r.voice_slot   <= 3'(free_idx);
            end
          end
          MODE_STOP: begin
            out_valid <= 1'b1;
            if ({29'd0, q_data.voice_index} < 32'(VOICES)) begin
              v_act_r[VW'(q_data.voice_index)] <= 1'b0;
            end else begin
              res_r.status <= ST_BAD_VOICE;
            end
          end
          default: out_valid <= 1'b1;
        endcase
      end
      case (state_r)
        BK_SCAN: begin
          if (vi_r != (VW+1)'(VOICES)) begin
            if (skip) begin
              v_act_r[vi] <= 1'b0;
              vi_r <= vi_r + (VW+1)'(1);
            end else begin
              v_pos_r[vi] <= pos_eff + PW'(1);
            end
          end
        end
        BK_READ: ;
        BK_MUL: begin
          prod_r <= 25'(mag) * 25'(v_gain_r[vi]);
          neg_r  <= rdata_r[15];
        end
        BK_ACC: begin
          if (sum > 19'sd32767) acc_r <= 18'sd32767;
          else if (sum < -19'sd32768) acc_r <= -18'sd32768;
          else acc_r <= 18'(sum);
          vi_r <= vi_r + (VW+1)'(1);
        end
        BK_DONE: begin
          if (!(out_valid && out_stall)) begin
            out_valid <= 1'b1;
            res_r.mixed_sample <= 16'(acc_r);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: hw/rtl/mvsm_front.sv
// front end: input skid register that accepts words and marks them for the queue
// depends on mvsm_pkg

module mvsm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mvsm_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_wr,
  output mvsm_pkg::in_item_t q_data
);
  import mvsm_pkg::*;

  logic     hold_r;
  in_item_t item_r;

  assign in_stall = hold_r;
  assign q_wr     = hold_r && !q_full;
  assign q_data   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      if (in_valid && !hold_r) begin
        hold_r <= 1'b1;
        item_r <= in_item;
      end else if (q_wr) begin
        hold_r <= 1'b0;
      end
    end
  end
endmodule

// File: hw/rtl/multi_voice_sample_mixer.sv
// top level of the multi-voice sample mixer
// depends on mvsm_pkg, mvsm_front, mvsm_queue, mvsm_back
//
// usage:
//   in channel: one word per command (tick, write sample, set sound, play,
//   play loop, stop). accepted when in_valid is high and in_stall is low.
//   the front register takes no new word while it holds one for the queue.
//   out channel: exactly one result word per command, in order.
//   a non-tick command has its result registered when the back end takes it
//   from the queue, after any wait behind earlier words.
//   a tick walks the voices one at a time through one shared multiplier:
//   each playing voice goes through scan, read, multiply and accumulate,
//   a free voice only through scan, and the mixed result follows in done.
//   the front register and two-entry queue let new words be taken while
//   the back end works or its result waits under out_stall.
//   reset clears the sound table and frees every voice; sample memory
//   holds whatever it held until written.
//   when out_stall is high with out_valid high, the result holds and the back end waits.

module multi_voice_sample_mixer #(
  parameter int VOICES       = mvsm_pkg::VOICES_DEF,
  parameter int SOUNDS       = mvsm_pkg::SOUNDS_DEF,
  parameter int SAMPLE_WORDS = mvsm_pkg::SAMPLE_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mvsm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mvsm_pkg::out_item_t out_item
);
  import mvsm_pkg::*;

  logic     q_wr, q_full, q_rd, q_empty;
  in_item_t f_data, q_data;

  mvsm_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .q_full, .q_wr, .q_data(f_data)
  );

  mvsm_queue u_queue (
    .clk, .rst_n, .wr_en(q_wr), .wr_data(f_data), .full(q_full),
    .rd_en(q_rd), .rd_data(q_data), .empty(q_empty)
  );

  mvsm_back #(.VOICES(VOICES), .SOUNDS(SOUNDS), .SAMPLE_WORDS(SAMPLE_WORDS)) u_back (
    .clk, .rst_n, .q_empty, .q_data, .q_rd,
    .out_valid, .out_stall, .out_data(out_item)
  );
endmodule
